// ===== design/dtc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the trouble code status table
// no dependencies

package dtc_pkg;

   localparam int ENTRIES  = 16;
   localparam int IDX_W    = 4;
   localparam int AGE_W    = 6;
   localparam int CNT_W    = 6;
   localparam int CODE_W   = 24;
   localparam int STATUS_W = 8;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   localparam logic [AGE_W-1:0] AGING_RESET = 6'd40;

   // status byte bits and special values
   localparam logic [STATUS_W-1:0] DTC_TEST_FAILED = 8'h01;
   localparam logic [STATUS_W-1:0] DTC_CONFIRMED   = 8'h08;
   localparam logic [STATUS_W-1:0] DTC_KEEP_TF     = 8'hfe;
   localparam logic [STATUS_W-1:0] DTC_KEEP_CONF   = 8'hf7;
   localparam logic [STATUS_W-1:0] DTC_PWRUP_OLD   = 8'h09;
   localparam logic [STATUS_W-1:0] DTC_MASK_ALL    = 8'h09;

   localparam logic SEL_CONFIRMED = 1'b1;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_AGING_ADDR = 3'd0;

   typedef enum logic [2:0] {
      MODE_WRITE      = 3'd0,
      MODE_COUNT      = 3'd1,
      MODE_REPORT     = 3'd2,
      MODE_CLEAR_ALL  = 3'd3,
      MODE_CLEAR_HIST = 3'd4,
      MODE_PWRUP_FIX  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0]          mode;
      logic [IDX_W-1:0]    entry_index;
      logic [7:0]          code_high;
      logic [7:0]          code_mid;
      logic [7:0]          code_low;
      logic                status_bit;
      logic                bit_value;
      logic [STATUS_W-1:0] status_mask;
   } req_item_type;

   typedef struct packed {
      logic [7:0]          report_code_high;
      logic [7:0]          report_code_mid;
      logic [7:0]          report_code_low;
      logic [STATUS_W-1:0] report_status;
      logic                entry_valid;
      logic [CNT_W-1:0]    match_count;
      logic                last;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic do_write;
      logic do_clear_all;
      logic do_clear_hist;
      logic do_fix;
      logic scan_start;
      logic scan_advance;
      logic count_inc;
      logic hold_load;
      logic out_line;
      logic out_summary;
      logic out_last;
   } dtc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] mode;
      logic       scan_match;
      logic       scan_last;
      logic       hold_valid;
      logic       out_free;
   } dtc_sts_type;

endpackage

// ===== design/dtc_status_table_core.sv =====
`timescale 1ns / 1ps
// top level of the trouble code status table: register port, sequencer, datapath
// depends on dtc_pkg, dtc_ctrl, dtc_datapath

// port group  direction  handshake                 payload
// req_        in         req_valid / req_stall     req_item (req_item_type)
// rsp_        out        rsp_valid / rsp_stall     rsp_item (rsp_item_type)
// csr_        in/out     psel/penable/pwrite/pready aging_limit at byte address 0
//
// one item at a time; write, clear-all, clear-history and power-up fix go
// through capture, then table update
// count makes one pass of the scan pointer over the table
// report makes one pass (mask 0x09) or two passes over the table, then a flush
// count and report take longer while rsp_stall holds back the result register
// synchronous reset clears the whole table and sets aging_limit to 40

module dtc_status_table_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dtc_pkg::req_item_type               req_item,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dtc_pkg::rsp_item_type               rsp_item,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dtc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [dtc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dtc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic [dtc_pkg::AGE_W-1:0] aging_limit_ff;
   logic [dtc_pkg::AGE_W-1:0] aging_limit_in;
   logic                      csr_write;

   dtc_pkg::dtc_cmd_type      cmd;
   dtc_pkg::dtc_sts_type      sts;

   // register port never waits
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == dtc_pkg::CSR_AGING_ADDR);

   // only the low six bits of the written word are kept
   assign aging_limit_in = csr_write ? csr_pwdata[dtc_pkg::AGE_W-1:0] : aging_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         aging_limit_ff <= dtc_pkg::AGING_RESET;
      end else begin
         aging_limit_ff <= aging_limit_in;
      end
   end

   // readback: aging_limit zero-extended, other addresses read zero
   assign csr_prdata = (csr_paddr == dtc_pkg::CSR_AGING_ADDR) ?
                       dtc_pkg::CSR_DATA_W'(aging_limit_ff) : '0;

   // sequencer: idle, execute, scan and flush states
   dtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table, scan pointer, held report line and result register
   dtc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .aging_limit (aging_limit_ff),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule

// ===== design/dtc_ctrl.sv =====
`timescale 1ns / 1ps
// request sequencer: accepts an item, runs the table operation or scan
// depends on dtc_pkg

module dtc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dtc_pkg::dtc_sts_type  sts,
   output dtc_pkg::dtc_cmd_type  cmd
);

   dtc_pkg::ctrl_state_type state_ff;
   dtc_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         dtc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = dtc_pkg::ST_EXEC;
            end
         end
         dtc_pkg::ST_EXEC: begin
            state_in = dtc_pkg::ST_IDLE;
            case (sts.mode)
               dtc_pkg::MODE_WRITE:      cmd.do_write      = 1'b1;
               dtc_pkg::MODE_CLEAR_ALL:  cmd.do_clear_all  = 1'b1;
               dtc_pkg::MODE_CLEAR_HIST: cmd.do_clear_hist = 1'b1;
               dtc_pkg::MODE_PWRUP_FIX:  cmd.do_fix        = 1'b1;
               dtc_pkg::MODE_COUNT, dtc_pkg::MODE_REPORT: begin
                  cmd.scan_start = 1'b1;
                  state_in       = dtc_pkg::ST_SCAN;
               end
               default: state_in = dtc_pkg::ST_IDLE;
            endcase
         end
         dtc_pkg::ST_SCAN: begin
            if (sts.mode == dtc_pkg::MODE_COUNT) begin
               cmd.count_inc    = sts.scan_match;
               cmd.scan_advance = 1'b1;
            end else if (!(sts.scan_match && sts.hold_valid && !sts.out_free)) begin
               // a new match pushes the held line out, not marked last
               cmd.hold_load    = sts.scan_match;
               cmd.out_line     = sts.scan_match && sts.hold_valid;
               cmd.scan_advance = 1'b1;
            end
            if (cmd.scan_advance && sts.scan_last) begin
               state_in = dtc_pkg::ST_FLUSH;
            end
         end
         dtc_pkg::ST_FLUSH: begin
            if (sts.out_free) begin
               if (sts.mode == dtc_pkg::MODE_REPORT && sts.hold_valid) begin
                  cmd.out_line = 1'b1;
                  cmd.out_last = 1'b1;
               end else begin
                  cmd.out_summary = 1'b1;
               end
               state_in = dtc_pkg::ST_IDLE;
            end
         end
         default: state_in = dtc_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== design/dtc_datapath.sv =====
`timescale 1ns / 1ps
// entry table, scan counters, held report line and result register
// depends on dtc_pkg

module dtc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  dtc_pkg::req_item_type          req_item,
   input  logic [dtc_pkg::AGE_W-1:0]      aging_limit,
   input  dtc_pkg::dtc_cmd_type           cmd,
   output dtc_pkg::dtc_sts_type           sts,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output dtc_pkg::rsp_item_type          rsp_item
);

   logic [dtc_pkg::STATUS_W-1:0] status_ff [dtc_pkg::ENTRIES];
   logic [dtc_pkg::STATUS_W-1:0] status_in [dtc_pkg::ENTRIES];
   logic [dtc_pkg::CODE_W-1:0]   code_ff   [dtc_pkg::ENTRIES];
   logic [dtc_pkg::CODE_W-1:0]   code_in   [dtc_pkg::ENTRIES];
   logic [dtc_pkg::AGE_W-1:0]    occ_ff    [dtc_pkg::ENTRIES];
   logic [dtc_pkg::AGE_W-1:0]    occ_in    [dtc_pkg::ENTRIES];

   dtc_pkg::req_item_type        req_ff, req_in;
   logic [dtc_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                         pass_ff, pass_in;
   logic [dtc_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                         hold_valid_ff, hold_valid_in;
   dtc_pkg::rsp_item_type        hold_ff, hold_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   dtc_pkg::rsp_item_type        rsp_ff, rsp_in;

   logic [dtc_pkg::IDX_W-1:0]    rd_idx;
   logic [dtc_pkg::STATUS_W-1:0] rd_status;
   logic [dtc_pkg::CODE_W-1:0]   rd_code;
   logic [dtc_pkg::AGE_W-1:0]    rd_occ;
   logic                         two_pass;
   logic                         match;
   logic                         write_ok;
   logic [dtc_pkg::CNT_W-1:0]    cnt_next;

   // one read port: write target during a write, scan pointer otherwise
   assign rd_idx    = cmd.do_write ? req_ff.entry_index : idx_ff;
   assign rd_status = status_ff[rd_idx];
   assign rd_code   = code_ff[rd_idx];
   assign rd_occ    = occ_ff[rd_idx];

   assign two_pass = (req_ff.mode == dtc_pkg::MODE_REPORT) &&
                     (req_ff.status_mask != dtc_pkg::DTC_MASK_ALL);
   assign write_ok = ({1'b0, req_ff.entry_index} < (dtc_pkg::IDX_W + 1)'(dtc_pkg::ENTRIES));
   assign cnt_next = cnt_ff + 1'b1;

   always_comb begin
      if (req_ff.mode == dtc_pkg::MODE_COUNT) begin
         match = (rd_status != '0) && ((rd_status & req_ff.status_mask) != '0);
      end else if (!two_pass) begin
         match = (rd_status != '0);
      end else if (!pass_ff) begin
         match = req_ff.status_mask[0] && rd_status[0];
      end else begin
         match = req_ff.status_mask[3] && rd_status[3];
      end
   end

   always_comb begin
      sts.mode       = req_ff.mode;
      sts.scan_match = match;
      sts.scan_last  = (idx_ff == dtc_pkg::LAST_IDX) && (pass_ff || !two_pass);
      sts.hold_valid = hold_valid_ff;
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // table update
   always_comb begin
      for (int i = 0; i < dtc_pkg::ENTRIES; i++) begin
         status_in[i] = status_ff[i];
         code_in[i]   = code_ff[i];
         occ_in[i]    = occ_ff[i];
         if (cmd.do_clear_all) begin
            status_in[i] = '0;
         end else if (cmd.do_clear_hist) begin
            status_in[i] = status_ff[i] & dtc_pkg::DTC_KEEP_CONF;
         end else if (cmd.do_fix && status_ff[i] == dtc_pkg::DTC_PWRUP_OLD) begin
            status_in[i] = dtc_pkg::DTC_CONFIRMED;
         end
      end
      if (cmd.do_write && write_ok) begin
         code_in[rd_idx] = {req_ff.code_high, req_ff.code_mid, req_ff.code_low};
         if (req_ff.status_bit == dtc_pkg::SEL_CONFIRMED) begin
            if (req_ff.bit_value) begin
               // aged out: count restarts at one, confirmed stays set
               occ_in[rd_idx]    = (rd_occ >= aging_limit) ? dtc_pkg::AGE_W'(1)
                                                            : rd_occ + 1'b1;
               status_in[rd_idx] = rd_status | dtc_pkg::DTC_CONFIRMED;
            end
         end else if (req_ff.bit_value) begin
            status_in[rd_idx] = rd_status | dtc_pkg::DTC_TEST_FAILED;
         end else begin
            status_in[rd_idx] = rd_status & dtc_pkg::DTC_KEEP_TF;
         end
      end
   end

   // scan, hold and output
   always_comb begin
      req_in        = cmd.load_req ? req_item : req_ff;
      idx_in        = idx_ff;
      pass_in       = pass_ff;
      cnt_in        = cnt_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      if (cmd.scan_start) begin
         idx_in        = '0;
         pass_in       = 1'b0;
         cnt_in        = '0;
         hold_valid_in = 1'b0;
      end
      if (cmd.scan_advance) begin
         if (idx_ff == dtc_pkg::LAST_IDX) begin
            idx_in  = '0;
            pass_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (cmd.count_inc) begin
         cnt_in = cnt_next;
      end
      if (cmd.out_line) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = hold_ff;
         rsp_in.last   = cmd.out_last;
         hold_valid_in = 1'b0;
      end
      if (cmd.hold_load) begin
         cnt_in                   = cnt_next;
         hold_valid_in            = 1'b1;
         hold_in.report_code_high = rd_code[23:16];
         hold_in.report_code_mid  = rd_code[15:8];
         hold_in.report_code_low  = rd_code[7:0];
         hold_in.report_status    = rd_status;
         hold_in.entry_valid      = 1'b1;
         hold_in.match_count      = cnt_next;
         hold_in.last             = 1'b0;
      end
      if (cmd.out_summary) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.match_count = cnt_ff;
         rsp_in.last        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dtc_pkg::ENTRIES; i++) begin
            status_ff[i] <= '0;
            code_ff[i]   <= '0;
            occ_ff[i]    <= '0;
         end
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         pass_ff       <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         for (int i = 0; i < dtc_pkg::ENTRIES; i++) begin
            status_ff[i] <= status_in[i];
            code_ff[i]   <= code_in[i];
            occ_ff[i]    <= occ_in[i];
         end
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
         pass_ff       <= pass_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== bench/tb_dtc_status_table_core.sv =====
`timescale 1ns / 1ps
// self-checking bench for dtc_status_table_core: directed table, then random phases
// depends on dtc_pkg and the design sources of dtc_status_table_core

module tb_dtc_status_table_core;
   import dtc_pkg::*;

   // modes six and seven are left unused by the block and must do nothing
   localparam logic [2:0] MODE_SPARE_LOW  = 3'd6;
   localparam logic [2:0] MODE_SPARE_HIGH = 3'd7;

   localparam logic [STATUS_W-1:0] MASK_EVERY = 8'hff;
   localparam logic [AGE_W-1:0]    AGE_LOW    = 6'd1;
   localparam logic [AGE_W-1:0]    AGE_HIGH   = 6'd63;

   localparam int DIRECTED_ROWS    = 26;
   localparam int PHASES           = 5;
   localparam int RANDOM_PER_PHASE = 24;
   // a two-pass report is the longest item, and this covers any item still in flight
   localparam int SETTLE_CYCLES    = 40;
   localparam int HOLD_CYCLES      = 300;
   localparam int PRINT_LIMIT      = 10;

   // one row of the directed table: an item and, where obvious, its single result
   typedef struct packed {
      req_item_type item;
      logic         typed;
      rsp_item_type want;
   } plan_row_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_item_type          req_item    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_item_type          rsp_item;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // own copy of the trouble code table and its register
   logic [STATUS_W-1:0] status_tab [ENTRIES] = '{default: '0};
   logic [CODE_W-1:0]   code_tab   [ENTRIES] = '{default: '0};
   logic [CNT_W-1:0]    occ_tab    [ENTRIES] = '{default: '0};
   logic [AGE_W-1:0]    aging_now  = AGING_RESET;

   rsp_item_type fresh_lines [$];   // lines caused by the item just accepted
   rsp_item_type lines_due   [$];   // report lines still to come out, oldest first

   plan_row_type directed_plan [DIRECTED_ROWS];
   logic [IDX_W-1:0] hot_entry [2];

   int error_count = 0;
   int burst_left  = 0;
   int stall_tick  = 0;
   int stall_style = 0;
   bit stall_next;
   logic hold_off      = 1'b0;
   logic holdoff_armed = 1'b0;

   dtc_status_table_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("%s", msg);
   endfunction

   function automatic string line_text(input rsp_item_type r);
      return $sformatf("code %02h%02h%02h status %02h valid %0b count %0d last %0b",
                       r.report_code_high, r.report_code_mid, r.report_code_low,
                       r.report_status, r.entry_valid, r.match_count, r.last);
   endfunction

   // one report line for table entry e, numbered by its place in the report
   function automatic void add_line(input int e);
      rsp_item_type r;
      r.report_code_high = code_tab[e][23:16];
      r.report_code_mid  = code_tab[e][15:8];
      r.report_code_low  = code_tab[e][7:0];
      r.report_status    = status_tab[e];
      r.entry_valid      = 1'b1;
      r.match_count      = CNT_W'(fresh_lines.size() + 1);
      r.last             = 1'b0;
      fresh_lines.push_back(r);
   endfunction

   // count answer, and also the lone line of an empty report
   function automatic void add_summary(input logic [CNT_W-1:0] n);
      rsp_item_type r;
      r             = '0;
      r.match_count = n;
      r.last        = 1'b1;
      fresh_lines.push_back(r);
   endfunction

   // table update and expected lines for one accepted item
   function automatic void predict_table(input req_item_type it);
      int           n;
      int           e;
      rsp_item_type tail;
      fresh_lines.delete();
      e = int'(it.entry_index);
      case (it.mode)
         MODE_WRITE: begin
            if (e < ENTRIES) begin
               code_tab[e] = {it.code_high, it.code_mid, it.code_low};
               if (it.status_bit == SEL_CONFIRMED) begin
                  // clearing the confirmed bit by a write leaves the status alone
                  if (it.bit_value) begin
                     // aging: count restarts and confirmed drops before the new hit
                     if (occ_tab[e] >= aging_now) begin
                        occ_tab[e]    = '0;
                        status_tab[e] = status_tab[e] & DTC_KEEP_CONF;
                     end
                     occ_tab[e]    = occ_tab[e] + 1'b1;
                     status_tab[e] = status_tab[e] | DTC_CONFIRMED;
                  end
               end else if (it.bit_value) begin
                  status_tab[e] = status_tab[e] | DTC_TEST_FAILED;
               end else begin
                  status_tab[e] = status_tab[e] & DTC_KEEP_TF;
               end
            end
         end
         MODE_COUNT: begin
            n = 0;
            for (int i = 0; i < ENTRIES; i++)
               if (status_tab[i] != '0 && (status_tab[i] & it.status_mask) != '0) n++;
            add_summary(CNT_W'(n));
         end
         MODE_REPORT: begin
            if (it.status_mask == DTC_MASK_ALL) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (status_tab[i] != '0) add_line(i);
            end else begin
               // test-failed pass first, then confirmed pass; an entry may show twice
               if ((it.status_mask & DTC_TEST_FAILED) != '0)
                  for (int i = 0; i < ENTRIES; i++)
                     if ((status_tab[i] & DTC_TEST_FAILED) != '0) add_line(i);
               if ((it.status_mask & DTC_CONFIRMED) != '0)
                  for (int i = 0; i < ENTRIES; i++)
                     if ((status_tab[i] & DTC_CONFIRMED) != '0) add_line(i);
            end
            if (fresh_lines.size() == 0) begin
               add_summary('0);
            end else begin
               tail      = fresh_lines.pop_back();
               tail.last = 1'b1;
               fresh_lines.push_back(tail);
            end
         end
         MODE_CLEAR_ALL: begin
            for (int i = 0; i < ENTRIES; i++) status_tab[i] = '0;
         end
         MODE_CLEAR_HIST: begin
            for (int i = 0; i < ENTRIES; i++) status_tab[i] = status_tab[i] & DTC_KEEP_CONF;
         end
         MODE_PWRUP_FIX: begin
            for (int i = 0; i < ENTRIES; i++)
               if (status_tab[i] == DTC_PWRUP_OLD) status_tab[i] = DTC_CONFIRMED;
         end
         default: ;
      endcase
   endfunction

   function automatic plan_row_type request_row(input logic [2:0] mode,
                                                input logic [IDX_W-1:0] idx,
                                                input logic [CODE_W-1:0] code,
                                                input logic sel, input logic val,
                                                input logic [STATUS_W-1:0] mask,
                                                input logic typed,
                                                input logic [CNT_W-1:0] n);
      plan_row_type r;
      r.item.mode        = mode;
      r.item.entry_index = idx;
      r.item.code_high   = code[23:16];
      r.item.code_mid    = code[15:8];
      r.item.code_low    = code[7:0];
      r.item.status_bit  = sel;
      r.item.bit_value   = val;
      r.item.status_mask = mask;
      r.typed            = typed;
      r.want             = '0;
      r.want.match_count = n;
      r.want.last        = 1'b1;
      return r;
   endfunction

   // random item: mostly writes aimed at two busy entries, with queries between
   function automatic req_item_type pick_request();
      req_item_type it;
      int           roll;
      it.code_high   = 8'($urandom());
      it.code_mid    = 8'($urandom());
      it.code_low    = 8'($urandom());
      it.entry_index = $urandom_range(0, 1) ? hot_entry[$urandom_range(0, 1)]
                                            : IDX_W'($urandom_range(0, ENTRIES - 1));
      it.status_bit  = 1'($urandom_range(0, 1));
      it.bit_value   = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
         0:       it.status_mask = DTC_MASK_ALL;
         1:       it.status_mask = DTC_TEST_FAILED;
         2:       it.status_mask = DTC_CONFIRMED;
         3:       it.status_mask = MASK_EVERY;
         default: it.status_mask = 8'($urandom());
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 55)      it.mode = MODE_WRITE;
      else if (roll < 67) it.mode = MODE_COUNT;
      else if (roll < 84) it.mode = MODE_REPORT;
      else if (roll < 87) it.mode = MODE_CLEAR_ALL;
      else if (roll < 92) it.mode = MODE_CLEAR_HIST;
      else if (roll < 98) it.mode = MODE_PWRUP_FIX;
      else                it.mode = $urandom_range(0, 1) ? MODE_SPARE_LOW : MODE_SPARE_HIGH;
      return it;
   endfunction

   // offer one item, wait for acceptance, then maybe leave a gap in the burst
   task automatic offer_item(input req_item_type it, input logic typed,
                             input rsp_item_type want);
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_table(it);
      if (typed) lines_due.push_back(want);
      else foreach (fresh_lines[k]) lines_due.push_back(fresh_lines[k]);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         // a quarter of the bursts run straight into the next one
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // drain: every expected line out, then let a trailing write finish
   task automatic settle_table();
      req_valid <= 1'b0;
      while (lines_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // optional write of the aging limit, always followed by a read back
   task automatic access_aging(input logic do_write, input logic [AGE_W-1:0] limit);
      if (do_write) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= CSR_AGING_ADDR;
         csr_pwdata  <= CSR_DATA_W'(limit);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         aging_now = limit;
      end
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_AGING_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(aging_now))
         flag_error($sformatf("aging_limit read back: expected %0d, got %0d",
                              aging_now, csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic void check_line(input rsp_item_type got);
      rsp_item_type want;
      if (lines_due.size() == 0) begin
         flag_error($sformatf("unexpected line: %s", line_text(got)));
         return;
      end
      want = lines_due.pop_front();
      if (got.report_code_high !== want.report_code_high ||
          got.report_code_mid  !== want.report_code_mid  ||
          got.report_code_low  !== want.report_code_low  ||
          got.report_status    !== want.report_status    ||
          got.entry_valid      !== want.entry_valid      ||
          got.match_count      !== want.match_count      ||
          got.last             !== want.last)
         flag_error($sformatf("line mismatch: expected %s, got %s",
                              line_text(want), line_text(got)));
   endfunction

   // result side: check what left at this edge, then pick the next stall value
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_line(rsp_item);
         stall_tick++;
         // the stall style is redrawn periodically from stall_tick, style 0 being no stall at all
         if (stall_tick % 64 == 0) stall_style = $urandom_range(0, 4);
         case (stall_style)
            0:       stall_next = 1'b0;
            1:       stall_next = ($urandom_range(0, 3) == 0);
            2:       stall_next = 1'($urandom_range(0, 1));
            3:       stall_next = (stall_tick % 3 == 0);
            default: stall_next = (stall_tick % 16 < 6);
         endcase
         rsp_stall <= hold_off | stall_next;
      end
   end

   // long hold-off on the result side so the block backs up into req_stall
   initial begin
      do @(posedge clock); while (!holdoff_armed);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // run limit, several times the slowest clean run
   initial begin
      #2_000_000;
      $display("tb_dtc_status_table_core: done, errors");
      $finish;
   end

   initial begin
      req_item_type     it;
      logic [AGE_W-1:0] limit_plan [PHASES];

      // directed table: typed rows are plain reads that match nothing
      directed_plan = '{
         // empty table straight after reset
         request_row(MODE_COUNT,      4'd0,  24'h000000, 1'b0, 1'b0, MASK_EVERY,   1'b1, 6'd0),
         request_row(MODE_REPORT,     4'd0,  24'h000000, 1'b0, 1'b0, DTC_MASK_ALL, 1'b1, 6'd0),
         // test-failed on the first entry, confirmed then test-failed on the last
         request_row(MODE_WRITE,      4'd0,  24'hffffff, 1'b0, 1'b1, 8'h00,        1'b0, 6'd0),
         request_row(MODE_WRITE,      4'd15, 24'h000000, 1'b1, 1'b1, 8'h00,        1'b0, 6'd0),
         request_row(MODE_WRITE,      4'd15, 24'ha55a3c, 1'b0, 1'b1, 8'h00,        1'b0, 6'd0),
         // each report flavour, including an entry listed twice
         request_row(MODE_REPORT,     4'd0,  24'h000000, 1'b0, 1'b0, DTC_MASK_ALL, 1'b0, 6'd0),
         request_row(MODE_REPORT,     4'd0,  24'h000000, 1'b0, 1'b0, DTC_TEST_FAILED,
                     1'b0, 6'd0),
         request_row(MODE_REPORT,     4'd0,  24'h000000, 1'b0, 1'b0, DTC_CONFIRMED, 1'b0, 6'd0),
         request_row(MODE_REPORT,     4'd0,  24'h000000, 1'b0, 1'b0, MASK_EVERY,   1'b0, 6'd0),
         request_row(MODE_COUNT,      4'd0,  24'h000000, 1'b0, 1'b0, DTC_CONFIRMED, 1'b0, 6'd0),
         // masks that can match nothing
         request_row(MODE_COUNT,      4'd0,  24'h000000, 1'b0, 1'b0, 8'h00,        1'b1, 6'd0),
         request_row(MODE_REPORT,     4'd0,  24'h000000, 1'b0, 1'b0, 8'h00,        1'b1, 6'd0),
         request_row(MODE_REPORT,     4'd0,  24'h000000, 1'b0, 1'b0, 8'hf6,        1'b1, 6'd0),
         request_row(MODE_COUNT,      4'd0,  24'h000000, 1'b0, 1'b0, 8'hf6,        1'b1, 6'd0),
         // power-up fix with every ignored field at its top
         request_row(MODE_PWRUP_FIX,  4'd15, 24'hffffff, 1'b1, 1'b1, MASK_EVERY,   1'b0, 6'd0),
         request_row(MODE_REPORT,     4'd0,  24'h000000, 1'b0, 1'b0, DTC_MASK_ALL, 1'b0, 6'd0),
         // test-failed clear, then a confirmed clear that only stores the code
         request_row(MODE_WRITE,      4'd0,  24'h123456, 1'b0, 1'b0, 8'h00,        1'b0, 6'd0),
         request_row(MODE_WRITE,      4'd3,  24'hff00ff, 1'b1, 1'b0, 8'h00,        1'b0, 6'd0),
         request_row(MODE_REPORT,     4'd0,  24'h000000, 1'b0, 1'b0, MASK_EVERY,   1'b0, 6'd0),
         // clear history leaves nothing set here
         request_row(MODE_CLEAR_HIST, 4'd0,  24'h000000, 1'b0, 1'b0, 8'h00,        1'b0, 6'd0),
         request_row(MODE_COUNT,      4'd0,  24'h000000, 1'b0, 1'b0, MASK_EVERY,   1'b1, 6'd0),
         // clear all wipes a fresh confirmed entry
         request_row(MODE_WRITE,      4'd7,  24'h80017f, 1'b1, 1'b1, 8'h00,        1'b0, 6'd0),
         request_row(MODE_CLEAR_ALL,  4'd0,  24'h000000, 1'b0, 1'b0, 8'h00,        1'b0, 6'd0),
         request_row(MODE_COUNT,      4'd0,  24'h000000, 1'b0, 1'b0, MASK_EVERY,   1'b1, 6'd0),
         // unused modes
         request_row(MODE_SPARE_LOW,  4'd15, 24'hffffff, 1'b1, 1'b1, MASK_EVERY,   1'b0, 6'd0),
         request_row(MODE_SPARE_HIGH, 4'd15, 24'hffffff, 1'b1, 1'b1, MASK_EVERY,   1'b0, 6'd0)
      };

      // both aging extremes, a tight small random limit, a random one and a fixed limit of 3
      limit_plan[0] = AGE_LOW;
      limit_plan[1] = AGE_HIGH;
      limit_plan[2] = AGE_W'($urandom_range(2, 8));
      limit_plan[3] = AGE_W'($urandom_range(int'(AGE_LOW), int'(AGE_HIGH)));
      limit_plan[4] = AGE_W'(3);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // register holds its reset value before any write
      access_aging(1'b0, AGING_RESET);

      foreach (directed_plan[r])
         offer_item(directed_plan[r].item, directed_plan[r].typed, directed_plan[r].want);
      settle_table();

      for (int p = 0; p < PHASES; p++) begin
         hot_entry[0] = IDX_W'($urandom_range(0, ENTRIES - 1));
         hot_entry[1] = IDX_W'($urandom_range(0, ENTRIES - 1));
         access_aging(1'b1, limit_plan[p]);

         // at the top limit, enough confirmed hits on one entry to reach aging
         if (p == 1) begin
            repeat (int'(AGE_HIGH) + 1) begin
               it             = pick_request();
               it.mode        = MODE_WRITE;
               it.entry_index = hot_entry[0];
               it.status_bit  = SEL_CONFIRMED;
               it.bit_value   = 1'b1;
               offer_item(it, 1'b0, '0);
            end
            it             = pick_request();
            it.mode        = MODE_REPORT;
            it.status_mask = DTC_CONFIRMED;
            offer_item(it, 1'b0, '0);
         end

         // fill every entry with both bits for the longest report, sent into a hold-off
         if (p == 2) begin
            for (int e = 0; e < ENTRIES; e++) begin
               for (int b = 0; b < 2; b++) begin
                  it             = pick_request();
                  it.mode        = MODE_WRITE;
                  it.entry_index = IDX_W'(e);
                  it.status_bit  = 1'(b);
                  it.bit_value   = 1'b1;
                  offer_item(it, 1'b0, '0);
               end
            end
            it             = pick_request();
            it.mode        = MODE_REPORT;
            it.status_mask = MASK_EVERY;
            holdoff_armed <= 1'b1;
            offer_item(it, 1'b0, '0);
         end

         repeat (RANDOM_PER_PHASE) offer_item(pick_request(), 1'b0, '0);
         settle_table();
      end

      if (error_count == 0) $display("tb_dtc_status_table_core: done, clean");
      else $display("tb_dtc_status_table_core: done, errors");
      $finish;
   end

endmodule

// ===== dtc_status_table_core.f =====
design/dtc_pkg.sv
design/dtc_ctrl.sv
design/dtc_datapath.sv
design/dtc_status_table_core.sv
bench/tb_dtc_status_table_core.sv
